@@ src/rv32_pkg.sv @@
package rv32_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned RIDX_W    = 5;

    typedef enum logic [1:0] {
        CMD_EXEC    = 2'd0,
        CMD_LDRET   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // load kinds (funct3 of the load)
    localparam logic [2:0] LK_B  = 3'd0;
    localparam logic [2:0] LK_H  = 3'd1;
    localparam logic [2:0] LK_BU = 3'd4;
    localparam logic [2:0] LK_HU = 3'd5;

    localparam logic [1:0] SZ_WORD = 2'd2;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        mem_valid;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [1:0]  mem_size;
        logic        reg_write_valid;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        waiting_load;
        logic        illegal;
    } t_result;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] instr_word;
        logic [31:0] load_data;
    } t_item;

    // register file write request from execute to the register file
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] idx;
        logic [31:0]       data;
    } t_rf_wr;

endpackage

@@ src/rv32_if.sv @@
interface rv32_in_if;
    logic          valid;
    logic          ready;
    rv32_pkg::t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rv32_out_if;
    logic            valid;
    logic            ready;
    rv32_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/rv32_regfile.sv @@
module rv32_regfile (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_ra,
    input  logic [4:0]            i_rb,
    input  rv32_pkg::t_rf_wr      i_wr,
    output logic [31:0]           o_a,
    output logic [31:0]           o_b
);
    // flop array, reset to zero; entry 0 never written
    logic [31:0] r_regs [rv32_pkg::REG_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rv32_pkg::REG_COUNT; i++) r_regs[i] <= '0;
        end else if (i_wr.en) begin
            r_regs[i_wr.idx] <= i_wr.data;
        end
    end

    // out-of-range and x0 read as zero; a write lands at the edge, so the
    // next transaction reads it straight from the array
    always_comb begin
        o_a = '0;
        o_b = '0;
        if (i_ra != '0 && 32'(i_ra) < rv32_pkg::REG_COUNT)
            o_a = r_regs[i_ra];
        if (i_rb != '0 && 32'(i_rb) < rv32_pkg::REG_COUNT)
            o_b = r_regs[i_rb];
    end
endmodule

@@ src/rv32_exec.sv @@
module rv32_exec (
    input  rv32_pkg::t_item   i_item,
    input  logic [31:0]       i_pc,
    input  logic [31:0]       i_start,
    input  logic              i_pend,
    input  logic [4:0]        i_pend_dest,
    input  logic [2:0]        i_pend_kind,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output rv32_pkg::t_result o_res,
    output rv32_pkg::t_rf_wr  o_wr,
    output logic              o_pc_we,
    output logic              o_pend_n,
    output logic              o_pend_set
);
    logic [31:0] w;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, pc4, res, ld_v, opb;
    logic [4:0]  shamt;
    logic        wb, ill, taken, slt, sltu, alt;

    assign w     = i_item.instr_word;
    assign op    = w[6:0];
    assign rd    = w[11:7];
    assign f3    = w[14:12];
    assign f7    = w[31:25];
    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_u = {w[31:12], 12'h000};
    assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign pc4   = i_pc + 32'd4;

    // ALU, operand b is rs2 or the I immediate
    always_comb begin
        opb   = (op == rv32_pkg::OP_REG) ? i_b : imm_i;
        shamt = opb[4:0];
        slt   = $signed(i_a) < $signed(opb);
        sltu  = i_a < opb;
        alt   = (f7 == rv32_pkg::F7_ALT);
        unique case (f3)
            rv32_pkg::F3_ADD:  res = (alt && op == rv32_pkg::OP_REG) ? i_a - opb : i_a + opb;
            rv32_pkg::F3_SLL:  res = i_a << shamt;
            rv32_pkg::F3_SLT:  res = {31'd0, slt};
            rv32_pkg::F3_SLTU: res = {31'd0, sltu};
            rv32_pkg::F3_XOR:  res = i_a ^ opb;
            rv32_pkg::F3_SR:   res = alt ? 32'($signed(i_a) >>> shamt) : i_a >> shamt;
            rv32_pkg::F3_OR:   res = i_a | opb;
            default:           res = i_a & opb;
        endcase
    end

    // load return formatting
    always_comb begin
        unique case (i_pend_kind)
            rv32_pkg::LK_B:  ld_v = {{24{i_item.load_data[7]}}, i_item.load_data[7:0]};
            rv32_pkg::LK_H:  ld_v = {{16{i_item.load_data[15]}}, i_item.load_data[15:0]};
            rv32_pkg::LK_BU: ld_v = {24'd0, i_item.load_data[7:0]};
            rv32_pkg::LK_HU: ld_v = {16'd0, i_item.load_data[15:0]};
            default:         ld_v = i_item.load_data;
        endcase
    end

    // decode and control
    always_comb begin
        o_res      = '0;
        o_res.next_pc = i_pc;
        o_wr       = '0;
        o_pc_we    = 1'b0;
        o_pend_n   = i_pend;
        o_pend_set = 1'b0;
        wb         = 1'b0;
        ill        = 1'b0;
        taken      = 1'b0;
        unique case (i_item.cmd)
            rv32_pkg::CMD_RESTART: begin
                o_res.next_pc = i_start;
                o_pc_we  = 1'b1;
                o_pend_n = 1'b0;
            end
            rv32_pkg::CMD_LDRET: begin
                if (i_pend) begin
                    o_pend_n = 1'b0;
                    if (i_pend_dest != '0 && 32'(i_pend_dest) < rv32_pkg::REG_COUNT) begin
                        o_wr.en  = 1'b1;
                        o_wr.idx = i_pend_dest;
                        o_wr.data = ld_v;
                    end
                end
            end
            rv32_pkg::CMD_EXEC: begin
                if (!i_pend) begin
                    o_res.next_pc = pc4;
                    unique case (op)
                        rv32_pkg::OP_LUI: begin
                            o_wr.data = imm_u; wb = 1'b1;
                        end
                        rv32_pkg::OP_AUIPC: begin
                            o_wr.data = i_pc + imm_u; wb = 1'b1;
                        end
                        rv32_pkg::OP_JAL: begin
                            o_wr.data = pc4; wb = 1'b1;
                            o_res.next_pc = i_pc + imm_j;
                        end
                        rv32_pkg::OP_JALR: begin
                            if (f3 != 3'd0) ill = 1'b1;
                            o_wr.data = pc4; wb = 1'b1;
                            o_res.next_pc = (i_a + imm_i) & ~32'd1;
                        end
                        rv32_pkg::OP_BRANCH: begin
                            unique case (f3)
                                3'd0: taken = (i_a == i_b);
                                3'd1: taken = (i_a != i_b);
                                3'd4: taken = $signed(i_a) < $signed(i_b);
                                3'd5: taken = !($signed(i_a) < $signed(i_b));
                                3'd6: taken = i_a < i_b;
                                3'd7: taken = i_a >= i_b;
                                default: ill = 1'b1;
                            endcase
                            if (taken) o_res.next_pc = i_pc + imm_b;
                        end
                        rv32_pkg::OP_LOAD: begin
                            if (f3 == 3'd3 || f3 == 3'd7) ill = 1'b1;
                            o_res.mem_valid = 1'b1;
                            o_res.mem_addr  = i_a + imm_i;
                            o_res.mem_size  = (f3 == 3'd6) ? rv32_pkg::SZ_WORD : f3[1:0];
                        end
                        rv32_pkg::OP_STORE: begin
                            if (f3 > 3'd2) ill = 1'b1;
                            o_res.mem_valid = 1'b1;
                            o_res.mem_write = 1'b1;
                            o_res.mem_addr  = i_a + imm_s;
                            o_res.mem_wdata = i_b;
                            o_res.mem_size  = f3[1:0];
                        end
                        rv32_pkg::OP_IMM: begin
                            if (f3 == rv32_pkg::F3_SLL && f7 != rv32_pkg::F7_ZERO) ill = 1'b1;
                            if (f3 == rv32_pkg::F3_SR && f7 != rv32_pkg::F7_ZERO && !alt)
                                ill = 1'b1;
                            o_wr.data = res; wb = 1'b1;
                        end
                        rv32_pkg::OP_REG: begin
                            if (!(f7 == rv32_pkg::F7_ZERO || (alt &&
                                  (f3 == rv32_pkg::F3_ADD || f3 == rv32_pkg::F3_SR))))
                                ill = 1'b1;
                            o_wr.data = res; wb = 1'b1;
                        end
                        default: ill = 1'b1;
                    endcase
                    if (ill) begin
                        o_res = '0;
                        o_res.next_pc = i_pc;
                        o_res.illegal = 1'b1;
                        o_wr  = '0;
                    end else begin
                        o_pc_we = 1'b1;
                        if (op == rv32_pkg::OP_LOAD) begin
                            o_pend_n   = 1'b1;
                            o_pend_set = 1'b1;
                        end
                        if (wb && rd != '0 && 32'(rd) < rv32_pkg::REG_COUNT) begin
                            o_wr.en  = 1'b1;
                            o_wr.idx = rd;
                        end else begin
                            o_wr = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        o_res.reg_write_valid = o_wr.en;
        o_res.reg_index       = o_wr.en ? o_wr.idx : '0;
        o_res.reg_value       = o_wr.en ? o_wr.data : '0;
        o_res.waiting_load    = o_pend_n;
    end
endmodule

@@ src/rv32i_instruction_execute.sv @@
// channel | dir | handshake   | payload
// i_item  | in  | valid/ready | cmd, instr_word, load_data
// o_res   | out | valid/ready | next_pc, mem_*, reg_*, waiting_load, illegal
// cfg     | in  | i_cfg_we    | start_address (i_cfg_wdata)
// One transaction per cycle while results are taken: input register, one
// combinational execute pass, result register. Register writes land when the
// item advances, so the next item reads them.
// Reset (i_rst_n low, synchronous) clears the registers, PC and start
// address to zero. A stalled result register holds and blocks the input
// register; both advance together when the sink takes the result.
module rv32i_instruction_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    rv32_in_if.sink     i_item,
    rv32_out_if.source  o_res
);
    logic              r_in_v, r_out_v, adv;
    rv32_pkg::t_item   r_in;
    rv32_pkg::t_result r_out, res;
    rv32_pkg::t_rf_wr  wr, rf_wr;
    logic [31:0]       r_pc, r_start, a, b;
    logic              r_pend, pend_n, pend_set, pc_we;
    logic [4:0]        r_pend_dest;
    logic [2:0]        r_pend_kind;

    // the execute stage fires when its result slot is free or being drained
    assign adv          = r_in_v && (!r_out_v || o_res.ready);
    assign i_item.ready = !r_in_v || adv;
    assign o_res.valid  = r_out_v;
    assign o_res.payload = r_out;

    // register file write only fires on advance
    assign rf_wr.en   = adv && wr.en;
    assign rf_wr.idx  = wr.idx;
    assign rf_wr.data = wr.data;

    rv32_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ra(r_in.instr_word[19:15]), .i_rb(r_in.instr_word[24:20]),
        .i_wr(rf_wr), .o_a(a), .o_b(b)
    );

    rv32_exec u_ex (
        .i_item(r_in), .i_pc(r_pc), .i_start(r_start), .i_pend(r_pend),
        .i_pend_dest(r_pend_dest), .i_pend_kind(r_pend_kind),
        .i_a(a), .i_b(b), .o_res(res), .o_wr(wr), .o_pc_we(pc_we),
        .o_pend_n(pend_n), .o_pend_set(pend_set)
    );

    // input and result registers, architectural state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v      <= 1'b0;
            r_out_v     <= 1'b0;
            r_pc        <= '0;
            r_start     <= '0;
            r_pend      <= 1'b0;
            r_pend_dest <= '0;
            r_pend_kind <= '0;
        end else begin
            if (i_cfg_we) r_start <= i_cfg_wdata;
            if (i_item.ready) r_in_v <= i_item.valid;
            if (adv) r_out_v <= 1'b1;
            else if (o_res.ready) r_out_v <= 1'b0;
            if (adv) begin
                if (pc_we) r_pc <= res.next_pc;
                r_pend <= pend_n;
                if (pend_set) begin
                    r_pend_dest <= r_in.instr_word[11:7];
                    r_pend_kind <= r_in.instr_word[14:12];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) r_in <= i_item.payload;
        if (adv) r_out <= res;
    end

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_res.ready) |=> $stable(r_out);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    a_ill_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && res.illegal) |-> (res.next_pc == r_pc && !wr.en))
        else $error("illegal item changed state");

    a_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.en |-> (rf_wr.idx != '0)) else $error("write to x0");
endmodule

@@ dv/exec_checker.sv @@
// Watches the instruction and result channels, predicts each result of the
// core and compares it with what the core returns.
module exec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    rv32_in_if          item,
    rv32_out_if         res,
    output int          o_errors,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import rv32_pkg::*;

    // predicted architectural state
    logic [31:0] start_addr;
    logic [31:0] pc;
    logic [31:0] regs [REG_COUNT];
    logic [4:0]  ld_dest;
    logic [2:0]  ld_kind;
    logic        ld_busy;

    t_result expected_results[$];

    function automatic logic [31:0] read_reg(input logic [4:0] idx);
        if (idx == 0 || idx >= REG_COUNT) begin
            return 32'd0;
        end
        return regs[idx];
    endfunction

    function automatic logic [31:0] alu_op(input logic [2:0] f3, input logic [31:0] a,
                                           input logic [31:0] b, input logic alt,
                                           input logic regop);
        case (f3)
            F3_ADD:  return (alt && regop) ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    // one accepted transaction: update state, return the expected result
    task automatic predict(input t_item it, output t_result r);
        logic [31:0] w, a, b, imm_i, imm_s, imm_b, imm_j, val, npc;
        logic [6:0]  op, f7;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic        wb, taken;
        w = it.instr_word;
        r = '0;
        r.next_pc = pc;
        if (it.cmd == CMD_RESTART) begin
            pc = start_addr;
            ld_busy = 1'b0;
            ld_dest = '0;
            ld_kind = '0;
            r.next_pc = start_addr;
        end else if (it.cmd == CMD_LDRET && ld_busy) begin
            case (ld_kind)
                LK_B:    val = {{24{it.load_data[7]}}, it.load_data[7:0]};
                LK_H:    val = {{16{it.load_data[15]}}, it.load_data[15:0]};
                LK_BU:   val = {24'd0, it.load_data[7:0]};
                LK_HU:   val = {16'd0, it.load_data[15:0]};
                default: val = it.load_data;
            endcase
            if (ld_dest != 0 && ld_dest < REG_COUNT) begin
                regs[ld_dest] = val;
                r.reg_write_valid = 1'b1;
                r.reg_index = ld_dest;
                r.reg_value = val;
            end
            ld_busy = 1'b0;
        end else if (it.cmd == CMD_EXEC && !ld_busy) begin
            op = w[6:0];
            rd = w[11:7];
            f3 = w[14:12];
            f7 = w[31:25];
            a = read_reg(w[19:15]);
            b = read_reg(w[24:20]);
            imm_i = {{20{w[31]}}, w[31:20]};
            imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
            imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            wb = 1'b0;
            val = '0;
            npc = pc + 32'd4;
            case (op)
                OP_LUI: begin
                    val = {w[31:12], 12'd0};
                    wb = 1'b1;
                end
                OP_AUIPC: begin
                    val = pc + {w[31:12], 12'd0};
                    wb = 1'b1;
                end
                OP_JAL: begin
                    val = pc + 32'd4;
                    npc = pc + imm_j;
                    wb = 1'b1;
                end
                OP_JALR: begin
                    if (f3 != F3_ADD) begin
                        r.illegal = 1'b1;
                    end else begin
                        val = pc + 32'd4;
                        npc = (a + imm_i) & ~32'd1;
                        wb = 1'b1;
                    end
                end
                OP_BRANCH: begin
                    taken = 1'b0;
                    case (f3)
                        3'd0: taken = (a == b);
                        3'd1: taken = (a != b);
                        3'd4: taken = $signed(a) < $signed(b);
                        3'd5: taken = $signed(a) >= $signed(b);
                        3'd6: taken = a < b;
                        3'd7: taken = a >= b;
                        default: r.illegal = 1'b1;
                    endcase
                    if (taken) begin
                        npc = pc + imm_b;
                    end
                end
                OP_LOAD: begin
                    if (f3 == 3'd3 || f3 == 3'd7) begin
                        r.illegal = 1'b1;
                    end else begin
                        r.mem_valid = 1'b1;
                        r.mem_addr = a + imm_i;
                        r.mem_size = (f3 == 3'd6) ? SZ_WORD : f3[1:0];
                        ld_busy = 1'b1;
                        ld_dest = rd;
                        ld_kind = f3;
                    end
                end
                OP_STORE: begin
                    if (f3 > 3'd2) begin
                        r.illegal = 1'b1;
                    end else begin
                        r.mem_valid = 1'b1;
                        r.mem_write = 1'b1;
                        r.mem_addr = a + imm_s;
                        r.mem_wdata = b;
                        r.mem_size = f3[1:0];
                    end
                end
                OP_IMM: begin
                    if ((f3 == F3_SLL && f7 != F7_ZERO) ||
                        (f3 == F3_SR && f7 != F7_ZERO && f7 != F7_ALT)) begin
                        r.illegal = 1'b1;
                    end else begin
                        val = alu_op(f3, a, imm_i, f3 == F3_SR && f7 == F7_ALT, 1'b0);
                        wb = 1'b1;
                    end
                end
                OP_REG: begin
                    if (!(f7 == F7_ZERO || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))))
                    begin
                        r.illegal = 1'b1;
                    end else begin
                        val = alu_op(f3, a, b, f7 == F7_ALT, 1'b1);
                        wb = 1'b1;
                    end
                end
                default: r.illegal = 1'b1;
            endcase
            if (!r.illegal) begin
                if (wb && rd != 0 && rd < REG_COUNT) begin
                    regs[rd] = val;
                    r.reg_write_valid = 1'b1;
                    r.reg_index = rd;
                    r.reg_value = val;
                end
                pc = npc;
                r.next_pc = npc;
            end
        end
        r.waiting_load = ld_busy;
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a,
                               inout bit bad);
        if (e !== a) begin
            bad = 1'b1;
            if (o_errors < 10) begin
                $display("[%0t] %s mismatch: expected %h, got %h", $realtime, name, e, a);
            end
        end
    endtask

    // monitor: configuration, accepted instructions, accepted results
    always @(posedge i_clk) begin
        t_result e, a;
        bit bad;
        if (!i_rst_n) begin
            start_addr = '0;
            pc = '0;
            for (int i = 0; i < REG_COUNT; i++) begin
                regs[i] = '0;
            end
            ld_dest = '0;
            ld_kind = '0;
            ld_busy = 1'b0;
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                start_addr = i_cfg_wdata;
            end
            if (item.valid && item.ready) begin
                predict(item.payload, e);
                expected_results.push_back(e);
            end
            if (res.valid && res.ready) begin
                a = res.payload;
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("[%0t] result with nothing expected: %h", $realtime, a);
                    end
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    bad = 1'b0;
                    check_field("next_pc", e.next_pc, a.next_pc, bad);
                    check_field("mem_valid", e.mem_valid, a.mem_valid, bad);
                    check_field("mem_write", e.mem_write, a.mem_write, bad);
                    check_field("mem_addr", e.mem_addr, a.mem_addr, bad);
                    check_field("mem_wdata", e.mem_wdata, a.mem_wdata, bad);
                    check_field("mem_size", e.mem_size, a.mem_size, bad);
                    check_field("reg_write_valid", e.reg_write_valid, a.reg_write_valid, bad);
                    check_field("reg_index", e.reg_index, a.reg_index, bad);
                    check_field("reg_value", e.reg_value, a.reg_value, bad);
                    check_field("waiting_load", e.waiting_load, a.waiting_load, bad);
                    check_field("illegal", e.illegal, a.illegal, bad);
                    if (bad) begin
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_outstanding <= expected_results.size();
    end
endmodule

@@ dv/tb.sv @@
// Drives instruction streams into the core under varying back-pressure.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rv32_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    int          errors;
    int          outstanding;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    rv32_in_if  item_if ();
    rv32_out_if res_if ();

    rv32i_instruction_execute dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_res       (res_if)
    );

    exec_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .item          (item_if),
        .res           (res_if),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result sink with random stalls
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one transaction and hold it until accepted
    task automatic send(input t_cmd cmd, input logic [31:0] w, input logic [31:0] ld);
        bit took;
        while ($urandom_range(99) < idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.payload <= '{cmd: cmd, instr_word: w, load_data: ld};
        forever begin
            @(negedge i_clk);
            took = item_if.ready;
            @(posedge i_clk);
            if (took) break;
        end
    endtask

    task automatic exec(input logic [31:0] w);
        send(CMD_EXEC, w, $urandom);
    endtask

    function automatic logic [4:0] rreg();
        // favour a few registers so results get reused
        return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(4));
    endfunction

    // a random legal instruction, loads flagged for a data return
    function automatic logic [31:0] rand_instr(output bit is_load);
        logic [31:0] r;
        logic [2:0]  f3;
        logic [6:0]  f7;
        r = $urandom;
        is_load = 1'b0;
        f3 = r[14:12];
        case ($urandom_range(9))
            0: return {r[31:12], rreg(), OP_LUI};
            1: return {r[31:12], rreg(), OP_AUIPC};
            2: return {r[31:12], rreg(), OP_JAL};
            3: return {r[31:20], rreg(), F3_ADD, rreg(), OP_JALR};
            4: begin
                if (f3 == 3'd2 || f3 == 3'd3) f3 = 3'd0;
                return {r[31:25], rreg(), rreg(), f3, r[11:7], OP_BRANCH};
            end
            5: begin
                if (f3 == 3'd3 || f3 == 3'd7) f3 = 3'd2;
                is_load = 1'b1;
                return {r[31:20], rreg(), f3, rreg(), OP_LOAD};
            end
            6: return {r[31:25], rreg(), rreg(), 3'($urandom_range(2)), r[11:7], OP_STORE};
            7, 8: begin
                f7 = (f3 == F3_SR && r[0]) ? F7_ALT : F7_ZERO;
                if (f3 == F3_SLL || f3 == F3_SR) begin
                    return {f7, r[24:20], rreg(), f3, rreg(), OP_IMM};
                end
                return {r[31:20], rreg(), f3, rreg(), OP_IMM};
            end
            default: begin
                f7 = ((f3 == F3_ADD || f3 == F3_SR) && r[0]) ? F7_ALT : F7_ZERO;
                return {f7, rreg(), rreg(), f3, rreg(), OP_REG};
            end
        endcase
    endfunction

    task automatic random_items(input int count);
        logic [31:0] w;
        bit ld;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(99)) inside
                [0:5]: send(t_cmd'($urandom_range(3)), $urandom, $urandom);
                [6:7]: send(CMD_RESTART, $urandom, $urandom);
                default: begin
                    w = rand_instr(ld);
                    exec(w);
                    // a load is normally followed by its data
                    if (ld && $urandom_range(9) != 0) begin
                        send(CMD_LDRET, $urandom, $urandom);
                        n++;
                    end
                end
            endcase
        end
    endtask

    // quiesce, write the start address, restart from it
    task automatic set_start(input logic [31:0] addr);
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= addr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        send(CMD_RESTART, '0, '0);
    endtask

    initial begin
        int idle_set [4];
        int stall_set [4];
        logic [31:0] starts [4];
        idle_set = '{0, 67, 0, 38};
        stall_set = '{0, 0, 67, 38};
        starts = '{32'hFFFF_FFFC, 32'h0, $urandom, 32'hFFFF_FFFF};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        item_if.valid = 1'b0;
        item_if.payload = '0;
        res_if.ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every operation class and the corner cases
        exec({20'hFFFFF, 5'd1, OP_LUI});                           // x1 = FFFFF000
        exec({12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM});               // x2 = -1
        exec({12'h7FF, 5'd2, F3_XOR, 5'd3, OP_IMM});
        exec({F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd4, OP_REG});          // SUB
        exec({F7_ALT, 5'd31, 5'd1, F3_SR, 5'd5, OP_IMM});          // SRAI by 31
        exec({F7_ZERO, 5'd3, 5'd2, F3_SLL, 5'd6, OP_REG});         // shift masked
        exec({12'hFFF, 5'd1, F3_SLTU, 5'd7, OP_IMM});
        exec({F7_ZERO, 5'd0, 5'd2, F3_SLT, 5'd8, OP_REG});
        exec({12'h123, 5'd2, F3_OR, 5'd0, OP_IMM});                // write to x0
        exec({20'h80000, 5'd9, OP_AUIPC});
        exec({12'h001, 5'd2, F3_ADD, 5'd10, OP_JALR});             // target wraps to zero
        exec({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd11, OP_JAL});
        exec({7'h7F, 5'd2, 5'd1, 3'd7, 5'h1F, OP_BRANCH});         // BGEU
        exec({7'h00, 5'd2, 5'd1, 3'd4, 5'h08, OP_BRANCH});         // BLT
        exec({7'h7F, 5'd2, 5'd1, 3'd2, 5'h00, OP_STORE});          // SW
        exec({12'h800, 5'd1, 3'd0, 5'd12, OP_LOAD});               // LB
        exec({12'h000, 5'd1, F3_ADD, 5'd13, OP_IMM});              // ignored: load pending
        send(CMD_LDRET, '0, 32'hFFFF_FF80);
        send(CMD_LDRET, '0, 32'hFFFF_FFFF);                        // nothing pending
        exec({12'h004, 5'd2, 3'd6, 5'd0, OP_LOAD});                // LWU into x0
        send(CMD_NONE, '1, '1);
        send(CMD_LDRET, '0, 32'hA5A5_5A5A);
        exec({12'h000, 5'd0, 3'd0, 5'd0, 7'h73});                  // SYSTEM: illegal
        exec({12'h000, 5'd0, 3'd3, 5'd1, OP_LOAD});                // bad load width
        send(CMD_RESTART, '0, '0);

        // random phases under different back-pressure and start addresses
        for (int p = 0; p < 4; p++) begin
            set_start(starts[p]);
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            random_items(285);
        end

        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
